// ===== rtl/pwve_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pwve_pkg;

  localparam int VOICES_DEF = 5;
  localparam int TBL_AW     = 8;
  localparam int TBL_DEPTH  = 256;
  localparam int PH_W       = 32;
  localparam int SMP_W      = 32;
  localparam int ENV_W      = 18;
  localparam int CNT_W      = 16;
  localparam int DAC_W      = 16;
  localparam int CFG_IW     = 3;
  localparam int PROD_W     = ENV_W + SMP_W;
  localparam int PROD_LSB   = 30;

  localparam logic [DAC_W-1:0] DAC_OFFSET = 16'd2048;

  localparam logic [CNT_W-1:0] ATTACK_STEP_RST    = 16'd327;
  localparam logic [CNT_W-1:0] DECAY_STEP_RST     = 16'd327;
  localparam logic [CNT_W-1:0] ATTACK_SAMPLES_RST = 16'd100;
  localparam logic [CNT_W-1:0] DECAY_SAMPLES_RST  = 16'd100;
  localparam logic [CNT_W-1:0] NOTE_SAMPLES_RST   = 16'd1000;

  typedef enum logic [1:0] {
    CMD_NOTE_ON = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_TBL_WR  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_ATTACK_STEP    = 3'd0,
    REG_DECAY_STEP     = 3'd1,
    REG_ATTACK_SAMPLES = 3'd2,
    REG_DECAY_SAMPLES  = 3'd3,
    REG_NOTE_SAMPLES   = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEEK,
    S_READ,
    S_MULT,
    S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic note_on;
    logic tbl_wr;
    logic tick_start;
    logic seek;
    logic fetch;
    logic mult;
    logic emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic has_next;
    logic cur_last;
  } dp_stat_t;

  function automatic logic signed [ENV_W-1:0] sat_env(input logic signed [ENV_W:0] v);
    logic signed [ENV_W-1:0] r;
    if (v[ENV_W] != v[ENV_W-1]) begin
      r = v[ENV_W] ? {1'b1, {(ENV_W-1){1'b0}}} : {1'b0, {(ENV_W-1){1'b1}}};
    end else begin
      r = v[ENV_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pwve_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pwve_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] note_step;
  logic [7:0]  table_index;
  logic signed [31:0] table_value;

  modport source (output valid, cmd, note_step, table_index, table_value, input ready);
  modport sink   (input valid, cmd, note_step, table_index, table_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/pwve_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pwve_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] dac_sample;
  logic        dac_channel;
  logic        last;

  modport source (output valid, dac_sample, dac_channel, last, input ready);
  modport sink   (input valid, dac_sample, dac_channel, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/pwve_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pwve_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/pwve_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pwve_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_cmd,
  output logic                    in_ready,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output pwve_pkg::dp_cmd_t       cmd,
  input  wire pwve_pkg::dp_stat_t stat
);
  import pwve_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   emit_ok;

  assign in_acc  = in_valid && (state_r == S_IDLE);
  assign emit_ok = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_cmd == CMD_TICK) state_nxt = S_SEEK;
      end
      S_SEEK: state_nxt = stat.has_next ? S_READ : S_IDLE;
      S_READ: state_nxt = S_MULT;
      S_MULT: state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit_ok) state_nxt = stat.cur_last ? S_IDLE : S_SEEK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          unique case (in_cmd)
            CMD_NOTE_ON: cmd.note_on    = 1'b1;
            CMD_TICK:    cmd.tick_start = 1'b1;
            CMD_TBL_WR:  cmd.tbl_wr     = 1'b1;
            default: ;
          endcase
        end
      end
      S_SEEK: cmd.seek  = stat.has_next;
      S_READ: cmd.fetch = 1'b1;
      S_MULT: cmd.mult  = 1'b1;
      S_EMIT: cmd.emit  = emit_ok;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pwve_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pwve_dp #(
  parameter int VOICES = pwve_pkg::VOICES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pwve_pkg::dp_cmd_t           cmd,
  output pwve_pkg::dp_stat_t               stat,
  input  wire logic [pwve_pkg::PH_W-1:0]   note_step,
  input  wire logic [pwve_pkg::TBL_AW-1:0] table_index,
  input  wire logic signed [pwve_pkg::SMP_W-1:0] table_value,
  input  wire logic                        cfg_we,
  input  wire logic [pwve_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [pwve_pkg::CNT_W-1:0]  cfg_data,
  output logic [pwve_pkg::DAC_W-1:0]       dac_sample,
  output logic                             dac_channel,
  output logic                             last
);
  import pwve_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  // settings
  logic [CNT_W-1:0] attack_step_r, decay_step_r;
  logic [CNT_W-1:0] attack_samples_r, decay_samples_r, note_samples_r;

  // per-voice state
  logic [PH_W-1:0]         phase_r   [VOICES];
  logic [PH_W-1:0]         step_r    [VOICES];
  logic signed [ENV_W-1:0] env_r     [VOICES];
  logic [CNT_W-1:0]        elapsed_r [VOICES];

  logic signed [SMP_W-1:0] wave_mem [TBL_DEPTH];
  logic signed [SMP_W-1:0] rd_r;

  logic [VW-1:0]    vidx_r;
  logic             par_r;
  logic [DAC_W-1:0] prod_r;
  logic [DAC_W-1:0] dac_r;
  logic             chan_r, last_r;

  logic [VOICES-1:0] active;
  logic              idle_hit;
  logic [VW-1:0]     idle_idx;
  logic [VW-1:0]     next_idx;
  logic              has_next, cur_last;

  logic [PH_W-1:0]         phase_sum;
  logic signed [ENV_W-1:0] cur_env;
  logic [CNT_W-1:0]        cur_el, el_inc;
  logic signed [PROD_W-1:0] prod;
  logic signed [ENV_W:0]   env_up, env_dn;
  logic signed [ENV_W-1:0] tail, el_s;
  logic signed [ENV_W-1:0] env_new;
  logic                    free_voice;

  always_comb begin
    for (int i = 0; i < VOICES; i++) active[i] = (step_r[i] != '0);
  end

  // lowest idle voice; lowest active voice at or above the pointer
  always_comb begin
    idle_hit = 1'b0;
    idle_idx = '0;
    has_next = 1'b0;
    next_idx = '0;
    cur_last = 1'b1;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!active[i]) begin
        idle_hit = 1'b1;
        idle_idx = VW'(i);
      end
      if (active[i] && i >= int'(vidx_r)) begin
        has_next = 1'b1;
        next_idx = VW'(i);
      end
      if (active[i] && i > int'(vidx_r)) cur_last = 1'b0;
    end
  end

  assign stat.has_next = has_next;
  assign stat.cur_last = cur_last;

  assign phase_sum = phase_r[vidx_r] + step_r[vidx_r];
  assign cur_env   = env_r[vidx_r];
  assign cur_el    = elapsed_r[vidx_r];
  assign el_inc    = cur_el + 1'b1;
  assign prod      = cur_env * rd_r;

  assign env_up = {cur_env[ENV_W-1], cur_env} + $signed({3'b000, attack_step_r});
  assign env_dn = {cur_env[ENV_W-1], cur_env} - $signed({3'b000, decay_step_r});
  assign tail   = $signed({2'b00, note_samples_r}) - $signed({2'b00, decay_samples_r});
  assign el_s   = $signed({2'b00, cur_el});

  always_comb begin
    if (cur_el < attack_samples_r) env_new = sat_env(env_up);
    else if (el_s > tail) env_new = sat_env(env_dn);
    else env_new = cur_env;
  end

  assign free_voice = (el_inc >= note_samples_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_step_r    <= ATTACK_STEP_RST;
      decay_step_r     <= DECAY_STEP_RST;
      attack_samples_r <= ATTACK_SAMPLES_RST;
      decay_samples_r  <= DECAY_SAMPLES_RST;
      note_samples_r   <= NOTE_SAMPLES_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK_STEP:    attack_step_r    <= cfg_data;
        REG_DECAY_STEP:     decay_step_r     <= cfg_data;
        REG_ATTACK_SAMPLES: attack_samples_r <= cfg_data;
        REG_DECAY_SAMPLES:  decay_samples_r  <= cfg_data;
        REG_NOTE_SAMPLES:   note_samples_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        phase_r[i]   <= '0;
        step_r[i]    <= '0;
        env_r[i]     <= '0;
        elapsed_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < VOICES; i++) begin
        if (cmd.note_on && idle_hit && i == int'(idle_idx)) step_r[i] <= note_step;
        if (cmd.fetch && i == int'(vidx_r)) phase_r[i] <= phase_sum;
        if (cmd.emit && i == int'(vidx_r)) begin
          if (free_voice) begin
            phase_r[i]   <= '0;
            step_r[i]    <= '0;
            env_r[i]     <= '0;
            elapsed_r[i] <= '0;
          end else begin
            env_r[i]     <= env_new;
            elapsed_r[i] <= el_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vidx_r <= '0;
      par_r  <= 1'b0;
    end else begin
      if (cmd.tick_start) begin
        vidx_r <= '0;
        par_r  <= 1'b0;
      end else if (cmd.seek) begin
        vidx_r <= next_idx;
      end else if (cmd.emit && !cur_last) begin
        vidx_r <= vidx_r + 1'b1;
      end
      if (cmd.fetch) par_r <= ~par_r;
    end
  end

  // waveform table
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) wave_mem[table_index] <= table_value;
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) rd_r <= wave_mem[phase_sum[PH_W-1 -: TBL_AW]];
  end

  // low 16 bits of the double shift are product bits 45..30
  always_ff @(posedge clk) begin
    if (cmd.mult) prod_r <= prod[PROD_LSB +: DAC_W];
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      dac_r  <= prod_r + DAC_OFFSET;
      chan_r <= par_r;
      last_r <= cur_last;
    end
  end

  assign dac_sample  = dac_r;
  assign dac_channel = chan_r;
  assign last        = last_r;

endmodule
`default_nettype wire

// ===== rtl/polyphonic_wavetable_voice_engine.sv =====
// channel  dir  handshake          payload
// in_bus   in   valid/ready        cmd, note_step, table_index, table_value
// out_bus  out  valid/ready        dac_sample, dac_channel, last
// cfg_bus  in   valid/ready (=1)   index, data
//
// Note-on and table write complete in the accepting cycle. A tick visits each
// active voice in index order: each voice goes seek, table read, multiply,
// output load, all through the one table read port and one 18x32 multiplier.
// Output stalls hold the engine at the output load. Input ready is high only
// between ticks. Synchronous active-low reset clears voices and settings;
// the waveform table has no reset.
`timescale 1ns / 1ps
`default_nettype none
module polyphonic_wavetable_voice_engine #(
  parameter int VOICES = pwve_pkg::VOICES_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  pwve_in_if.sink    in_bus,
  pwve_out_if.source out_bus,
  pwve_cfg_if.sink   cfg_bus
);
  import pwve_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  assign cfg_bus.ready = 1'b1;

  pwve_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_cmd    (in_bus.cmd),
    .in_ready  (in_bus.ready),
    .out_ready (out_bus.ready),
    .out_valid (out_bus.valid),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  pwve_dp #(
    .VOICES(VOICES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (dp_cmd),
    .stat        (dp_stat),
    .note_step   (in_bus.note_step),
    .table_index (in_bus.table_index),
    .table_value (in_bus.table_value),
    .cfg_we      (cfg_bus.valid),
    .cfg_index   (cfg_bus.index),
    .cfg_data    (cfg_bus.data),
    .dac_sample  (out_bus.dac_sample),
    .dac_channel (out_bus.dac_channel),
    .last        (out_bus.last)
  );

endmodule
`default_nettype wire

// ===== rtl/pwve_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pwve_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_cmd,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_dac_sample,
  input wire logic        out_dac_channel,
  input wire logic        out_last
);
  import pwve_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dac_sample) &&
      $stable(out_dac_channel) && $stable(out_last))
    else $error("stalled result changed");

  // note-on and table write finish in the accepting cycle
  a_short_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd != CMD_TICK |=> in_ready)
    else $error("non-tick request left input blocked");

  // a tick always blocks input once accepted
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_TICK |=> !in_ready)
    else $error("tick did not start processing");

  // more results pending after a non-final one; the final one may have been
  // loaded at the same edge
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready || out_last)
    else $error("input reopened before final result of tick");

endmodule

bind polyphonic_wavetable_voice_engine pwve_checker u_pwve_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_bus.valid),
  .in_ready        (in_bus.ready),
  .in_cmd          (in_bus.cmd),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_dac_sample  (out_bus.dac_sample),
  .out_dac_channel (out_bus.dac_channel),
  .out_last        (out_bus.last)
);
`default_nettype wire
